>>> rtl/assert_macros.svh
// Assertion macros shared by the protected memory map decoder RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, expr) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/pmmd_pkg.sv
// Package for the protected memory map decoder: codes, widths and shared types.
// No dependencies; used by pmmd_ctrl and the top level.
`timescale 1ns / 1ps

package pmmd_pkg;

	localparam int unsigned AddrW    = 16;
	localparam int unsigned IdxW     = 15;
	localparam int unsigned ByteW    = 8;

	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_LOAD  = 2'd2;

	localparam logic [3:0] NIB_PORT_A = 4'h0;
	localparam logic [3:0] NIB_PORT_B = 4'h1;
	localparam logic [3:0] NIB_FLAG   = 4'h2;

	typedef enum logic [1:0] {
		REGION_RAM  = 2'd0,
		REGION_ROM  = 2'd1,
		REGION_PORT = 2'd2,
		REGION_NONE = 2'd3
	} region_t;

	typedef enum logic [1:0] {
		RSEL_ZERO = 2'd0,
		RSEL_RAM  = 2'd1,
		RSEL_ROM  = 2'd2,
		RSEL_PORT = 2'd3
	} rsel_t;

	typedef struct packed {
		logic ram_we;
		logic ram_re;
		logic rom_we;
		logic rom_re;
	} mem_ctl_t;

endpackage

>>> rtl/pmmd_mem.sv
// Byte memory with one write port and one registered read port.
// Depends on nothing; instanced for RAM and ROM by the top level.
`timescale 1ns / 1ps

module pmmd_mem #(
	parameter int unsigned AddrW = 15,
	parameter int unsigned DataW = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [DataW-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [DataW-1:0] rdata
);

	localparam int unsigned Depth = 1 << AddrW;

	logic [DataW-1:0] mem [Depth];
	logic [DataW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/pmmd_ctrl.sv
// Address decode, port registers and user bit of the protected memory map decoder.
// Depends on pmmd_pkg; instanced by the top level.
`timescale 1ns / 1ps

module pmmd_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  logic [1:0]                   command,
	input  logic [pmmd_pkg::AddrW-1:0]   bus_address,
	input  logic [pmmd_pkg::ByteW-1:0]   write_data,
	input  logic                         vector_pull,
	output pmmd_pkg::mem_ctl_t           mem_ctl,
	output pmmd_pkg::region_t            region,
	output pmmd_pkg::rsel_t              rsel,
	output logic [pmmd_pkg::ByteW-1:0]   port_rdata,
	output logic                         user_next
);

	logic [pmmd_pkg::ByteW-1:0] port_a_q;
	logic [pmmd_pkg::ByteW-1:0] port_b_q;
	logic [pmmd_pkg::ByteW-1:0] flag_q;
	logic [pmmd_pkg::ByteW-1:0] port_a_eff;
	logic                       user;
	logic                       upper;
	logic                       is_load;
	logic                       is_write;
	logic                       is_read;
	logic [3:0]                 nib;
	pmmd_pkg::region_t          dec;
	logic                       wr_a;
	logic                       wr_b;
	logic                       wr_flag;

	assign port_a_eff = vector_pull ? {port_a_q[pmmd_pkg::ByteW-1:1], 1'b0} : port_a_q;
	assign user       = port_a_eff[0];
	assign upper      = bus_address[15];
	assign nib        = bus_address[3:0];
	assign is_load    = (command == pmmd_pkg::CMD_LOAD);
	assign is_write   = (command == pmmd_pkg::CMD_WRITE);
	assign is_read    = !is_load && !is_write;

	always_comb begin
		if (!user) begin
			if (!upper) begin
				dec = pmmd_pkg::REGION_RAM;
			end else if (bus_address[14:10] == 5'd0) begin
				dec = pmmd_pkg::REGION_PORT;
			end else begin
				dec = pmmd_pkg::REGION_ROM;
			end
		end else if (upper) begin
			dec = pmmd_pkg::REGION_ROM;
		end else if (bus_address[14:12] == 3'd0) begin
			dec = pmmd_pkg::REGION_RAM;
		end else begin
			dec = pmmd_pkg::REGION_NONE;
		end
	end

	assign region = is_load ? pmmd_pkg::REGION_ROM : dec;

	always_comb begin
		if (!is_read) begin
			rsel = pmmd_pkg::RSEL_ZERO;
		end else begin
			unique case (dec)
				pmmd_pkg::REGION_RAM:  rsel = pmmd_pkg::RSEL_RAM;
				pmmd_pkg::REGION_ROM:  rsel = pmmd_pkg::RSEL_ROM;
				pmmd_pkg::REGION_PORT: rsel = pmmd_pkg::RSEL_PORT;
				default:               rsel = pmmd_pkg::RSEL_ZERO;
			endcase
		end
	end

	always_comb begin
		unique case (nib)
			pmmd_pkg::NIB_PORT_A: port_rdata = port_a_eff;
			pmmd_pkg::NIB_PORT_B: port_rdata = port_b_q;
			pmmd_pkg::NIB_FLAG:   port_rdata = flag_q;
			default:              port_rdata = '0;
		endcase
	end

	assign wr_a    = is_write && (dec == pmmd_pkg::REGION_PORT) && (nib == pmmd_pkg::NIB_PORT_A);
	assign wr_b    = is_write && (dec == pmmd_pkg::REGION_PORT) && (nib == pmmd_pkg::NIB_PORT_B);
	assign wr_flag = is_write && (dec == pmmd_pkg::REGION_PORT) && (nib == pmmd_pkg::NIB_FLAG);

	assign user_next = wr_a ? write_data[0] : port_a_eff[0];

	assign mem_ctl.ram_we = fire && is_write && (dec == pmmd_pkg::REGION_RAM);
	assign mem_ctl.ram_re = fire && is_read && (dec == pmmd_pkg::REGION_RAM);
	assign mem_ctl.rom_we = fire && is_load;
	assign mem_ctl.rom_re = fire && is_read && (dec == pmmd_pkg::REGION_ROM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_a_q <= '0;
			port_b_q <= '0;
			flag_q   <= '0;
		end else if (fire) begin
			port_a_q <= wr_a ? write_data : port_a_eff;
			if (wr_b) begin
				port_b_q <= write_data;
			end
			if (wr_flag) begin
				flag_q <= write_data;
			end
		end
	end

endmodule

>>> rtl/protected_memory_map_decoder.sv
// Top level of the protected memory map decoder: handshake, RAM clear and result stage.
// Depends on pmmd_pkg, pmmd_ctrl, pmmd_mem and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes one bus access per cycle while the output is not stalled and returns one
// result per access: an input register feeds the decode and the memory ports, and
// the registered memory read forms the result stage. After reset the 32768-byte
// RAM is cleared one byte per cycle, and s_tready stays low until the sweep ends.
// ROM contents are undefined until loaded with the load command.
module protected_memory_map_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // bus_address[15:0], write_data[23:16], vector_pull[24], zero
	input  logic [1:0]  s_tuser,   // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // read_data[7:0], user_mode[8], zero
	output logic [1:0]  m_tuser    // region[1:0]
);

	logic                            clearing_q;
	logic [pmmd_pkg::IdxW-1:0]       clr_cnt_q;
	logic                            valid_s1;
	logic [1:0]                      command_s1;
	logic [pmmd_pkg::AddrW-1:0]      addr_s1;
	logic [pmmd_pkg::ByteW-1:0]      wdata_s1;
	logic                            vpull_s1;
	logic                            valid_s2;
	pmmd_pkg::region_t               region_s2;
	pmmd_pkg::rsel_t                 rsel_s2;
	logic [pmmd_pkg::ByteW-1:0]      port_s2;
	logic                            user_s2;
	logic                            adv;
	logic                            fire;
	pmmd_pkg::mem_ctl_t              mem_ctl;
	pmmd_pkg::region_t               region;
	pmmd_pkg::rsel_t                 rsel;
	logic [pmmd_pkg::ByteW-1:0]      port_rdata;
	logic                            user_next;
	logic                            ram_we;
	logic [pmmd_pkg::IdxW-1:0]       ram_waddr;
	logic [pmmd_pkg::ByteW-1:0]      ram_wdata;
	logic [pmmd_pkg::ByteW-1:0]      ram_rdata;
	logic [pmmd_pkg::ByteW-1:0]      rom_rdata;
	logic [pmmd_pkg::ByteW-1:0]      read_data;

	assign adv      = !valid_s2 || m_tready;
	assign fire     = valid_s1 && adv;
	assign s_tready = !clearing_q && (!valid_s1 || adv);

	// sweep RAM to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (&clr_cnt_q) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			command_s1 <= s_tuser;
			addr_s1    <= s_tdata[15:0];
			wdata_s1   <= s_tdata[23:16];
			vpull_s1   <= s_tdata[24];
		end
	end

	pmmd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.command     (command_s1),
		.bus_address (addr_s1),
		.write_data  (wdata_s1),
		.vector_pull (vpull_s1),
		.mem_ctl     (mem_ctl),
		.region      (region),
		.rsel        (rsel),
		.port_rdata  (port_rdata),
		.user_next   (user_next)
	);

	assign ram_we    = clearing_q || mem_ctl.ram_we;
	assign ram_waddr = clearing_q ? clr_cnt_q : addr_s1[pmmd_pkg::IdxW-1:0];
	assign ram_wdata = clearing_q ? '0 : wdata_s1;

	pmmd_mem #(
		.AddrW (15),
		.DataW (8)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (mem_ctl.ram_re),
		.raddr (addr_s1[pmmd_pkg::IdxW-1:0]),
		.rdata (ram_rdata)
	);

	pmmd_mem #(
		.AddrW (15),
		.DataW (8)
	) u_rom (
		.clk   (clk),
		.we    (mem_ctl.rom_we),
		.waddr (addr_s1[pmmd_pkg::IdxW-1:0]),
		.wdata (wdata_s1),
		.re    (mem_ctl.rom_re),
		.raddr (addr_s1[pmmd_pkg::IdxW-1:0]),
		.rdata (rom_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			region_s2 <= region;
			rsel_s2   <= rsel;
			port_s2   <= port_rdata;
			user_s2   <= user_next;
		end
	end

	always_comb begin
		case (rsel_s2)
			pmmd_pkg::RSEL_RAM:  read_data = ram_rdata;
			pmmd_pkg::RSEL_ROM:  read_data = rom_rdata;
			pmmd_pkg::RSEL_PORT: read_data = port_s2;
			default:             read_data = '0;
		endcase
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, user_s2, read_data};
	assign m_tuser  = region_s2;

	`ASSERT_IMPLIES(a_no_item_while_clearing, clk, arst_n, clearing_q, !valid_s1)
	`ASSERT_IMPLIES(a_clear_owns_ram_port, clk, arst_n, clearing_q, !mem_ctl.ram_we)
	`ASSERT_ALWAYS(a_one_mem_access, clk, arst_n, $onehot0(mem_ctl))
	`ASSERT_IMPLIES(a_ram_read_region, clk, arst_n,
		valid_s2 && (rsel_s2 == pmmd_pkg::RSEL_RAM), region_s2 == pmmd_pkg::REGION_RAM)

endmodule
